### rtl/gelu_pkg.sv
// Shared types, constants and the tanh breakpoint table for the GELU/tanh activation unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package gelu_pkg;

	// Lane count and sample format (signed Q4.12)
	localparam int Lanes     = 4;
	localparam int DataW     = 16;
	localparam int MagW      = DataW + 1;     // |x| up to 32768
	localparam int NumStages = 7;             // lane pipeline depth

	// Piecewise-linear tanh table geometry
	localparam int TanhSeg     = 64;
	localparam int TanhSegHalf = TanhSeg / 2;
	localparam int SegW        = $clog2(TanhSeg);
	localparam int TabIdxW     = $clog2(TanhSeg + 1);
	localparam int UaFracW     = 14;          // |u| below 4.0 in Q12
	localparam int SegProdW    = UaFracW + SegW;
	localparam int TabW        = 16;          // Q15 magnitude, up to 1.0

	// Q20 constants: sqrt(2/pi) and the cubic coefficient
	localparam logic [19:0] KSqrtQ20  = 20'd836643;
	localparam logic [15:0] KCubicQ20 = 16'd46887;

	// Function select
	typedef enum logic {
		MODE_GELU = 1'b0,
		MODE_TANH = 1'b1
	} mode_t;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic [NumStages-1:0] ld;
		logic                 ld_out;
	} pipe_ctl_t;

	typedef logic [TabW-1:0]   tab_entry_t;
	typedef tab_entry_t [TanhSeg:0] tab_t;

	// Unsigned quotient by shift and subtract, used while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Breakpoints of |tanh| in Q15 at u = 4*k/TanhSeg.
	// tanh(u) = (1-z)/(1+z) with z = exp(-2u), z from a Q30 series raised to the eighth power by squaring.
	// Evaluated at elaboration only.
	function automatic tab_t build_tanh_tab();
		tab_t                tab;
		logic [63:0]         f;
		logic [63:0]         term;
		logic [63:0]         z;
		logic signed [63:0]  sum;
		int unsigned         k;
		int unsigned         j;
		int unsigned         s;
		tab = '0;
		for (k = 0; k <= TanhSeg; k++) begin
			f    = udiv64((64'(k) << 30) + 64'(TanhSegHalf), 64'(TanhSeg));
			// exp(-f) by Taylor series, each term floored
			sum  = 64'sd1 <<< 30;
			term = 64'd1 << 30;
			for (j = 1; j <= 24; j++) begin
				term = udiv64((term * f) >> 30, 64'(j));
				if (j[0]) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > (64'sd1 <<< 30)) begin
				sum = 64'sd1 <<< 30;
			end
			z = 64'(sum);
			// z^8 by three rounded squarings
			for (s = 0; s < 3; s++) begin
				z = (z * z + (64'd1 << 29)) >> 30;
			end
			if (z > (64'd1 << 30)) begin
				z = 64'd1 << 30;
			end
			tab[k] = TabW'(udiv64(((64'd1 << 30) - z) * 64'd65536 + ((64'd1 << 30) + z),
				64'd2 * ((64'd1 << 30) + z)));
		end
		return tab;
	endfunction

endpackage

### rtl/gelu_ctl.sv
// Pipeline control: per-stage valid bits, back-pressure chain and the end-of-vector flag.
// Depends on gelu_pkg for the stage count and the control struct.

module gelu_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 last_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 last_out,
	output gelu_pkg::pipe_ctl_t  ctl
);

	localparam int N = gelu_pkg::NumStages;

	logic [N-1:0] vld_q;
	logic [N-1:0] lst_q;
	logic         out_vld_q;
	logic         out_lst_q;
	logic [N:0]   rdy;

	// A stage may load when it is empty or its successor loads this cycle
	always_comb begin
		rdy[N] = !out_vld_q || !out_stall;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctl.ld     = rdy[N-1:0];
	assign ctl.ld_out = rdy[N];
	assign in_stall   = !rdy[0];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (rdy[N]) begin
				out_vld_q <= vld_q[N-1];
			end
		end
	end

	// End-of-vector flag rides along with the beat
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			lst_q[0] <= last_in;
		end
		for (int k = 1; k < N; k++) begin
			if (rdy[k]) begin
				lst_q[k] <= lst_q[k-1];
			end
		end
		if (rdy[N]) begin
			out_lst_q <= lst_q[N-1];
		end
	end

	assign out_valid = out_vld_q;
	assign last_out  = out_lst_q;

endmodule

### rtl/gelu_lane.sv
// One activation lane: seven-stage pipeline computing GELU (tanh form) or tanh of one sample.
// Depends on gelu_pkg for formats, constants, the tanh table and the control struct.

module gelu_lane (
	input  logic                          clk,
	input  gelu_pkg::pipe_ctl_t           ctl,
	input  gelu_pkg::mode_t               mode,
	input  logic signed [gelu_pkg::DataW-1:0] x,
	output logic [gelu_pkg::DataW-1:0]    y
);

	localparam int MW  = gelu_pkg::MagW;
	localparam int DW  = gelu_pkg::DataW;
	localparam int SW  = gelu_pkg::SegW;
	localparam int TIW = gelu_pkg::TabIdxW;
	localparam int PW  = gelu_pkg::SegProdW;
	localparam int FW  = gelu_pkg::UaFracW;
	localparam int TW  = gelu_pkg::TabW;

	localparam gelu_pkg::tab_t TanhTab = gelu_pkg::build_tanh_tab();

	// Stage 1: magnitude and square
	logic [MW-1:0]     a_in;
	logic [2*MW-1:0]   sq_c;
	logic [MW-1:0]     a_s1;
	logic              neg_s1;
	gelu_pkg::mode_t   mode_s1;
	logic [30:0]       sq_s1;

	assign a_in = x[DW-1] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
	assign sq_c = {{MW{1'b0}}, a_in} * {{MW{1'b0}}, a_in};

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			a_s1    <= a_in;
			neg_s1  <= x[DW-1];
			mode_s1 <= mode;
			sq_s1   <= sq_c[30:0];
		end
	end

	// Stage 2: cube
	logic [47:0]       cube_c;
	logic [MW-1:0]     a_s2;
	logic              neg_s2;
	gelu_pkg::mode_t   mode_s2;
	logic [45:0]       a3_s2;

	assign cube_c = {17'd0, sq_s1} * {31'd0, a_s1};

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			a_s2    <= a_s1;
			neg_s2  <= neg_s1;
			mode_s2 <= mode_s1;
			a3_s2   <= cube_c[45:0];
		end
	end

	// Stage 3: cubic term, x + 0.044715*x^3
	logic [61:0]       cub_p;
	logic [MW-1:0]     cub_c;
	logic [MW-1:0]     a_s3;
	logic              neg_s3;
	gelu_pkg::mode_t   mode_s3;
	logic [MW:0]       sum_s3;

	assign cub_p = {16'd0, a3_s2} * {46'd0, gelu_pkg::KCubicQ20} + (62'd1 << 43);
	assign cub_c = cub_p[60:44];

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			a_s3    <= a_s2;
			neg_s3  <= neg_s2;
			mode_s3 <= mode_s2;
			sum_s3  <= {1'b0, a_s2} + {1'b0, cub_c};
		end
	end

	// Stage 4: tanh argument, segment index and offset
	logic [37:0]       arg_p;
	logic [MW-1:0]     ua_c;
	logic [PW-1:0]     seg_p;
	logic [MW-1:0]     a_s4;
	logic              neg_s4;
	gelu_pkg::mode_t   mode_s4;
	logic              sat_s4;
	logic [SW-1:0]     idx_s4;
	logic [FW-1:0]     rem_s4;

	assign arg_p = {20'd0, sum_s3} * {18'd0, gelu_pkg::KSqrtQ20} + (38'd1 << 19);
	assign ua_c  = (mode_s3 == gelu_pkg::MODE_TANH) ? a_s3 : arg_p[36:20];
	assign seg_p = PW'(ua_c[FW-1:0]) * PW'(gelu_pkg::TanhSeg);

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			a_s4    <= a_s3;
			neg_s4  <= neg_s3;
			mode_s4 <= mode_s3;
			sat_s4  <= (ua_c >= (17'd1 << FW));
			idx_s4  <= seg_p[PW-1:FW];
			rem_s4  <= seg_p[FW-1:0];
		end
	end

	// Stage 5: table lookup of the segment end points
	logic [TIW-1:0]    lo_idx;
	logic [TIW-1:0]    hi_idx;
	logic [TW-1:0]     lo_c;
	logic [TW-1:0]     hi_c;
	logic [MW-1:0]     a_s5;
	logic              neg_s5;
	gelu_pkg::mode_t   mode_s5;
	logic              sat_s5;
	logic [FW-1:0]     rem_s5;
	logic [TW-1:0]     lo_s5;
	logic [TW-1:0]     d_s5;

	assign lo_idx = TIW'(idx_s4);
	assign hi_idx = lo_idx + TIW'(1);
	assign lo_c   = TanhTab[lo_idx];
	assign hi_c   = TanhTab[hi_idx];

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			a_s5    <= a_s4;
			neg_s5  <= neg_s4;
			mode_s5 <= mode_s4;
			sat_s5  <= sat_s4;
			rem_s5  <= rem_s4;
			lo_s5   <= lo_c;
			d_s5    <= (hi_c > lo_c) ? (hi_c - lo_c) : '0;
		end
	end

	// Stage 6: linear interpolation, |tanh| in Q15
	logic [30:0]       interp_p;
	logic [TW-1:0]     t_c;
	logic [MW-1:0]     a_s6;
	logic              neg_s6;
	gelu_pkg::mode_t   mode_s6;
	logic [TW-1:0]     t_s6;

	assign interp_p = {15'd0, d_s5} * {17'd0, rem_s5} + 31'd8192;
	assign t_c      = sat_s5 ? 16'h8000 : (lo_s5 + interp_p[29:14]);

	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			a_s6    <= a_s5;
			neg_s6  <= neg_s5;
			mode_s6 <= mode_s5;
			t_s6    <= t_c;
		end
	end

	// Stage 7: output scaling, saturation and sign
	logic [MW-1:0]     fac_c;
	logic [33:0]       gp_c;
	logic [MW-1:0]     t4_c;
	logic [MW:0]       mag_c;
	logic [MW-1:0]     cap_c;
	logic [MW-1:0]     negv_c;
	logic [DW-1:0]     y_s7;

	assign fac_c  = neg_s6 ? (17'h08000 - {1'b0, t_s6}) : (17'h08000 + {1'b0, t_s6});
	assign gp_c   = {17'd0, a_s6} * {17'd0, fac_c} + 34'd32768;
	assign t4_c   = {1'b0, t_s6} + 17'd4;
	assign mag_c  = (mode_s6 == gelu_pkg::MODE_TANH) ? (MW + 1)'(t4_c[MW-1:3]) : gp_c[33:16];

	always_comb begin
		if (!neg_s6 && (mag_c > 18'd32767)) begin
			cap_c = 17'd32767;
		end else if (neg_s6 && (mag_c > 18'd32768)) begin
			cap_c = 17'd32768;
		end else begin
			cap_c = mag_c[MW-1:0];
		end
	end

	assign negv_c = 17'h10000 - cap_c;

	always_ff @(posedge clk) begin
		if (ctl.ld[6]) begin
			y_s7 <= neg_s6 ? negv_c[DW-1:0] : cap_c[DW-1:0];
		end
	end

	assign y = y_s7;

endmodule

### rtl/gelu_tanh_activation_unit.sv
// Top level of the four-lane GELU / tanh activation unit.
// Depends on gelu_pkg, gelu_ctl and gelu_lane.

// Takes one beat of four signed Q4.12 samples per unstalled cycle and returns one beat of
// four Q4.12 activations, in order, with last_out copied from last_in. cfg_wdata written
// with cfg_we selects GELU in its tanh form (0, the reset value) or plain tanh (1).
// Throughput is one beat per clock while out_stall is low. A beat passes through the
// lane pipeline (square, cube, cubic term, tanh argument, table lookup, interpolation,
// output scaling, the first loaded at the accepting edge) and then the output register,
// where out_valid is presented. in_stall rises only when every stage is full behind a
// stalled output beat. The tanh is a 64-segment piecewise-linear table over |u| < 4
// and saturates to +-1 beyond; results saturate.

module gelu_tanh_activation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_lane0,
	input  logic signed [15:0] x_lane1,
	input  logic signed [15:0] x_lane2,
	input  logic signed [15:0] x_lane3,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] y_lane0,
	output logic signed [15:0] y_lane1,
	output logic signed [15:0] y_lane2,
	output logic signed [15:0] y_lane3,
	output logic               last_out
);

	localparam int L  = gelu_pkg::Lanes;
	localparam int DW = gelu_pkg::DataW;

	gelu_pkg::mode_t     mode_q;
	gelu_pkg::pipe_ctl_t ctl;
	logic signed [DW-1:0] x_arr [L];
	logic [DW-1:0]       y_lane [L];
	logic [DW-1:0]       y_q [L];

	// Function select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gelu_pkg::MODE_GELU;
		end else if (cfg_we) begin
			mode_q <= gelu_pkg::mode_t'(cfg_wdata);
		end
	end

	// Handshake and valid tracking
	gelu_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_out  (last_out),
		.ctl       (ctl)
	);

	assign x_arr[0] = x_lane0;
	assign x_arr[1] = x_lane1;
	assign x_arr[2] = x_lane2;
	assign x_arr[3] = x_lane3;

	// Lanes
	for (genvar l = 0; l < L; l++) begin : g_lane
		gelu_lane u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.mode (mode_q),
			.x    (x_arr[l]),
			.y    (y_lane[l])
		);
	end

	// Merge the lane results into one output beat
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			for (int l = 0; l < L; l++) begin
				y_q[l] <= y_lane[l];
			end
		end
	end

	assign y_lane0 = $signed(y_q[0]);
	assign y_lane1 = $signed(y_q[1]);
	assign y_lane2 = $signed(y_q[2]);
	assign y_lane3 = $signed(y_q[3]);

endmodule
